FILE: sv/fstp_pkg.sv
package fstp_pkg;

  localparam int DataBits = 32;
  localparam int FracBits = 16;

  // Q16.16 constants
  localparam logic signed [31:0] ONE_Q    = 32'sd65536;
  localparam logic signed [31:0] C3_Q     = 32'sd19661;   // 0.3
  localparam logic signed [31:0] C7_Q     = 32'sd45875;   // 0.7
  localparam logic signed [31:0] FUZZ_LIM = 32'sd196608;  // 3.0
  localparam logic [20:0]        HALF_W   = 21'd98304;    // 1.5
  localparam logic [16:0]        MEMB_THR = 17'd655;      // 0.01
  localparam logic [21:0]        DEN_MIN  = 22'd6;        // 0.0001
  localparam logic [18:0]        RECIP3   = 19'd349526;   // ceil(2^20/3)
  localparam logic signed [31:0] MAX_D    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_D    = 32'sh8000_0000;

  localparam int DivSteps = 31;

  // register indexes
  localparam logic [2:0] REG_BASE_P   = 3'd0;
  localparam logic [2:0] REG_BASE_I   = 3'd1;
  localparam logic [2:0] REG_BASE_D   = 3'd2;
  localparam logic [2:0] REG_ESCALE   = 3'd3;
  localparam logic [2:0] REG_CSCALE   = 3'd4;
  localparam logic [2:0] REG_DRV_UP   = 3'd5;
  localparam logic [2:0] REG_DRV_LO   = 3'd6;
  localparam logic [2:0] REG_ACC_LIM  = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_MULE,
    ST_MULC,
    ST_XC,
    ST_MEMB,
    ST_RULE,
    ST_GMUL,
    ST_GDIV,
    ST_GWAIT,
    ST_PMUL,
    ST_IMUL,
    ST_DMUL,
    ST_DLAT,
    ST_F3,
    ST_F7,
    ST_SUM,
    ST_OUT,
    ST_DONE
  } fstp_state_e;

  // rule bases, row = error level, column = change level, -3..3
  localparam logic signed [3:0] RULE_P [0:48] = '{
     4'sd3,  4'sd3,  4'sd2,  4'sd2,  4'sd1,  4'sd0,  4'sd0,
     4'sd3,  4'sd3,  4'sd2,  4'sd1,  4'sd1,  4'sd0, -4'sd1,
     4'sd2,  4'sd2,  4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd1,
     4'sd2,  4'sd2,  4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd2,
     4'sd1,  4'sd1,  4'sd0, -4'sd1, -4'sd1, -4'sd2, -4'sd2,
     4'sd1,  4'sd0, -4'sd1, -4'sd2, -4'sd2, -4'sd2, -4'sd3,
     4'sd0,  4'sd0, -4'sd2, -4'sd2, -4'sd2, -4'sd3, -4'sd3};

  localparam logic signed [3:0] RULE_I [0:48] = '{
    -4'sd3, -4'sd3, -4'sd2, -4'sd2, -4'sd1,  4'sd0,  4'sd0,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, -4'sd1,  4'sd0,  4'sd0,
    -4'sd3, -4'sd2, -4'sd1, -4'sd1,  4'sd0,  4'sd1,  4'sd1,
    -4'sd2, -4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd2,  4'sd2,
    -4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd1,  4'sd2,  4'sd3,
     4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd2,  4'sd3,  4'sd3,
     4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd2,  4'sd3,  4'sd3};

  localparam logic signed [3:0] RULE_D [0:48] = '{
     4'sd1, -4'sd1, -4'sd3, -4'sd3, -4'sd3, -4'sd2,  4'sd1,
     4'sd1, -4'sd1, -4'sd3, -4'sd2, -4'sd2, -4'sd1,  4'sd0,
     4'sd0, -4'sd1, -4'sd2, -4'sd2, -4'sd1, -4'sd1,  4'sd0,
     4'sd0, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1,  4'sd0,
     4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,
     4'sd3, -4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd3,
     4'sd3,  4'sd2,  4'sd2,  4'sd2,  4'sd1,  4'sd1,  4'sd3};

endpackage

FILE: sv/fuzzy_self_tuning_pid.sv
// Channel   | Dir | Handshake              | Payload
// s_*       | in  | s_tvalid_i/s_tready_o  | tdata: setpoint, measured; tuser: kind
// m_*       | out | m_tvalid_o/m_tready_i  | tdata: drive, tuned p, i, d gains
// APB       | in  | psel/penable/pready    | 8 registers at 4*index
//
// A control sample's time is set by the rule scan and by three divides in the
// shared divider, skipped when the weight sum is below DEN_MIN; a clear skips both.
// One item at a time; s_tready_o is high in idle only.
// A finished result sits in the output register; the next item can be
// taken while it waits, the one after stalls until it is taken.
// Reset (asynchronous, active low) zeroes loop state and loads register defaults.
module fuzzy_self_tuning_pid (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [63:0]  s_tdata_i,   // [31:0] setpoint, [63:32] measured
  input  logic         s_tuser_i,   // kind: 0 sample, 1 clear
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [127:0] m_tdata_o,   // drive, tuned_prop, tuned_integ, tuned_deriv, pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  fstp_pkg::fstp_state_e state_q, state_d;

  // config registers
  logic [30:0]        base_p_q, base_i_q, base_d_q, escale_q, cscale_q, acc_lim_q;
  logic signed [31:0] drv_up_q, drv_lo_q;

  // loop state and item data
  logic signed [31:0] sp_q, ms_q, err_q, chg_q, prev_q, accum_q, ds_q;
  logic signed [31:0] term_p_q, term_i_q, term_d_q, t3_q;
  logic signed [18:0] xe_q, xc_q;
  logic [16:0]        me_q [7];
  logic [16:0]        mc_q [7];
  logic [2:0]         idx_q, row_q, col_q;
  logic [5:0]         k_q;
  logic [1:0]         g_q;
  logic signed [25:0] num_p_q, num_i_q, num_d_q;
  logic [21:0]        den_q;
  logic [30:0]        kp_q, ki_q, kd_q;
  logic               dneg_q;
  logic signed [31:0] drive_q;

  logic         m_valid_q;
  logic [127:0] m_data_q;

  // shared units
  logic signed [31:0] mul_a, mul_b, mul_q;
  logic [63:0]        mul_prod;
  logic               mul_neg;
  logic               div_start, div_done;
  logic [30:0]        div_quot;

  fstp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(mul_prod),
    .neg_o (mul_neg),
    .q_o   (mul_q)
  );

  fstp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mul_prod),
    .divisor_i (24'(den_q) * 24'd3),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // triangular membership of level idx, with the small-value cut
  function automatic logic [16:0] memb(input logic signed [18:0] x, input logic [2:0] idx);
    logic signed [3:0]  lvl;
    logic signed [20:0] ctr, diff;
    logic [20:0]        dabs;
    logic [17:0]        n;
    logic [36:0]        prod;
    logic [16:0]        v;
    lvl  = $signed({1'b0, idx}) - 4'sd3;
    ctr  = {{17{lvl[3]}}, lvl} <<< 16;
    diff = {{2{x[18]}}, x} - ctr;
    dabs = diff[20] ? (~diff + 21'd1) : diff;
    v    = '0;
    if (dabs < fstp_pkg::HALF_W) begin
      n    = 18'((fstp_pkg::HALF_W - dabs) << 1);
      prod = {1'b0, n} * {18'd0, fstp_pkg::RECIP3};
      v    = prod[36:20];
    end
    return (v > fstp_pkg::MEMB_THR) ? v : 17'd0;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) return fstp_pkg::MAX_D;
    if (v < -33'sh0_8000_0000) return fstp_pkg::MIN_D;
    return v[31:0];
  endfunction

  function automatic logic signed [18:0] fclamp(input logic signed [31:0] v);
    if (v > fstp_pkg::FUZZ_LIM) return fstp_pkg::FUZZ_LIM[18:0];
    if (v < -fstp_pkg::FUZZ_LIM) return 19'(-fstp_pkg::FUZZ_LIM);
    return v[18:0];
  endfunction

  // rule scan terms
  logic [16:0]        w_min;
  logic signed [25:0] w_ext;
  assign w_min = (me_q[row_q] < mc_q[col_q]) ? me_q[row_q] : mc_q[col_q];
  assign w_ext = {9'd0, w_min};

  // gain select
  logic signed [25:0] num_sel;
  logic [30:0]        base_sel;
  always_comb begin
    unique case (g_q)
      2'd0:    begin num_sel = num_p_q; base_sel = base_p_q; end
      2'd1:    begin num_sel = num_i_q; base_sel = base_i_q; end
      2'd2:    begin num_sel = num_d_q; base_sel = base_d_q; end
      default: begin num_sel = num_p_q; base_sel = base_p_q; end
    endcase
  end

  // tuned gain from divider result
  logic signed [33:0] delta, gsum;
  logic [30:0]        tuned;
  assign delta = dneg_q ? -$signed({3'd0, div_quot}) : $signed({3'd0, div_quot});
  assign gsum  = $signed({3'd0, base_sel}) + delta;
  always_comb begin
    if (gsum < 0) begin
      tuned = '0;
    end else if (gsum > 34'sh0_7FFF_FFFF) begin
      tuned = 31'h7FFF_FFFF;
    end else begin
      tuned = gsum[30:0];
    end
  end

  // accumulator update
  logic signed [31:0] acc_sat, acc_new, lim_s;
  assign lim_s   = $signed({1'b0, acc_lim_q});
  assign acc_sat = sat33(33'(accum_q) + 33'(err_q));
  always_comb begin
    acc_new = acc_sat;
    if (acc_new > lim_s) acc_new = lim_s;
    if (acc_new < -lim_s) acc_new = -lim_s;
  end

  // output sum and clamps
  logic signed [33:0] dsum;
  logic signed [31:0] drv_sat, drv_new;
  assign dsum = 34'(term_p_q) + 34'(term_i_q) + 34'(ds_q);
  always_comb begin
    if (dsum > 34'sh0_7FFF_FFFF) begin
      drv_sat = fstp_pkg::MAX_D;
    end else if (dsum < -34'sh0_8000_0000) begin
      drv_sat = fstp_pkg::MIN_D;
    end else begin
      drv_sat = dsum[31:0];
    end
    drv_new = drv_sat;
    if (drv_new > drv_up_q) drv_new = drv_up_q;
    if (drv_new < drv_lo_q) drv_new = drv_lo_q;
  end

  logic s_fire, out_free, den_ok;
  assign s_tready_o = (state_q == fstp_pkg::ST_IDLE);
  assign s_fire     = s_tvalid_i & s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;
  assign den_ok     = den_q >= fstp_pkg::DEN_MIN;

  // next state, multiplier operands, divider start
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      fstp_pkg::ST_IDLE: begin
        if (s_fire) state_d = s_tuser_i ? fstp_pkg::ST_DONE : fstp_pkg::ST_ERR;
      end
      fstp_pkg::ST_ERR:  state_d = fstp_pkg::ST_MULE;
      fstp_pkg::ST_MULE: begin
        mul_a   = err_q;
        mul_b   = {1'b0, escale_q};
        state_d = fstp_pkg::ST_MULC;
      end
      fstp_pkg::ST_MULC: begin
        mul_a   = chg_q;
        mul_b   = {1'b0, cscale_q};
        state_d = fstp_pkg::ST_XC;
      end
      fstp_pkg::ST_XC:   state_d = fstp_pkg::ST_MEMB;
      fstp_pkg::ST_MEMB: if (idx_q == 3'd6) state_d = fstp_pkg::ST_RULE;
      fstp_pkg::ST_RULE: if (k_q == 6'd48) state_d = fstp_pkg::ST_GMUL;
      fstp_pkg::ST_GMUL: begin
        mul_a   = 32'(num_sel);
        mul_b   = {2'b0, base_sel[30:1]};
        state_d = fstp_pkg::ST_GDIV;
      end
      fstp_pkg::ST_GDIV: begin
        if (den_ok) begin
          div_start = 1'b1;
          state_d   = fstp_pkg::ST_GWAIT;
        end else begin
          state_d = (g_q == 2'd2) ? fstp_pkg::ST_PMUL : fstp_pkg::ST_GMUL;
        end
      end
      fstp_pkg::ST_GWAIT: begin
        if (div_done) state_d = (g_q == 2'd2) ? fstp_pkg::ST_PMUL : fstp_pkg::ST_GMUL;
      end
      fstp_pkg::ST_PMUL: begin
        mul_a   = {1'b0, kp_q};
        mul_b   = err_q;
        state_d = fstp_pkg::ST_IMUL;
      end
      fstp_pkg::ST_IMUL: begin
        mul_a   = {1'b0, ki_q};
        mul_b   = accum_q;
        state_d = fstp_pkg::ST_DMUL;
      end
      fstp_pkg::ST_DMUL: begin
        mul_a   = {1'b0, kd_q};
        mul_b   = chg_q;
        state_d = fstp_pkg::ST_DLAT;
      end
      fstp_pkg::ST_DLAT: state_d = fstp_pkg::ST_F3;
      fstp_pkg::ST_F3: begin
        mul_a   = fstp_pkg::C3_Q;
        mul_b   = term_d_q;
        state_d = fstp_pkg::ST_F7;
      end
      fstp_pkg::ST_F7: begin
        mul_a   = fstp_pkg::C7_Q;
        mul_b   = ds_q;
        state_d = fstp_pkg::ST_SUM;
      end
      fstp_pkg::ST_SUM:  state_d = fstp_pkg::ST_OUT;
      fstp_pkg::ST_OUT:  state_d = fstp_pkg::ST_DONE;
      fstp_pkg::ST_DONE: if (out_free) state_d = fstp_pkg::ST_IDLE;
      default:           state_d = fstp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fstp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // loop state, config, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      accum_q   <= '0;
      ds_q      <= '0;
      m_valid_q <= 1'b0;
      base_p_q  <= '0;
      base_i_q  <= '0;
      base_d_q  <= '0;
      escale_q  <= 31'd65536;
      cscale_q  <= 31'd65536;
      drv_up_q  <= 32'sd65536000;
      drv_lo_q  <= -32'sd65536000;
      acc_lim_q <= 31'd32768000;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          fstp_pkg::REG_BASE_P:  base_p_q  <= pwdata[30:0];
          fstp_pkg::REG_BASE_I:  base_i_q  <= pwdata[30:0];
          fstp_pkg::REG_BASE_D:  base_d_q  <= pwdata[30:0];
          fstp_pkg::REG_ESCALE:  escale_q  <= pwdata[30:0];
          fstp_pkg::REG_CSCALE:  cscale_q  <= pwdata[30:0];
          fstp_pkg::REG_DRV_UP:  drv_up_q  <= pwdata;
          fstp_pkg::REG_DRV_LO:  drv_lo_q  <= pwdata;
          fstp_pkg::REG_ACC_LIM: acc_lim_q <= pwdata[30:0];
          default: ;
        endcase
      end
      if (s_fire && s_tuser_i) begin
        prev_q  <= '0;
        accum_q <= '0;
        ds_q    <= '0;
      end
      if (state_q == fstp_pkg::ST_PMUL) accum_q <= acc_new;
      if (state_q == fstp_pkg::ST_SUM) ds_q <= sat33(33'(t3_q) + 33'(mul_q));
      if (state_q == fstp_pkg::ST_OUT) prev_q <= err_q;
      if (state_q == fstp_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fstp_pkg::ST_IDLE: begin
        sp_q    <= s_tdata_i[31:0];
        ms_q    <= s_tdata_i[63:32];
        drive_q <= '0;
        kp_q    <= base_p_q;
        ki_q    <= base_i_q;
        kd_q    <= base_d_q;
      end
      fstp_pkg::ST_ERR: begin
        err_q <= sat33(33'(sp_q) - 33'(ms_q));
        chg_q <= sat33(33'(sat33(33'(sp_q) - 33'(ms_q))) - 33'(prev_q));
      end
      fstp_pkg::ST_MULC: xe_q <= fclamp(mul_q);
      fstp_pkg::ST_XC: begin
        xc_q    <= fclamp(mul_q);
        idx_q   <= '0;
        row_q   <= '0;
        col_q   <= '0;
        k_q     <= '0;
        g_q     <= '0;
        num_p_q <= '0;
        num_i_q <= '0;
        num_d_q <= '0;
        den_q   <= '0;
      end
      fstp_pkg::ST_MEMB: begin
        me_q[idx_q] <= memb(xe_q, idx_q);
        mc_q[idx_q] <= memb(xc_q, idx_q);
        idx_q       <= idx_q + 3'd1;
      end
      fstp_pkg::ST_RULE: begin
        num_p_q <= num_p_q + w_ext * {{22{fstp_pkg::RULE_P[k_q][3]}}, fstp_pkg::RULE_P[k_q]};
        num_i_q <= num_i_q + w_ext * {{22{fstp_pkg::RULE_I[k_q][3]}}, fstp_pkg::RULE_I[k_q]};
        num_d_q <= num_d_q + w_ext * {{22{fstp_pkg::RULE_D[k_q][3]}}, fstp_pkg::RULE_D[k_q]};
        den_q   <= den_q + 22'(w_min);
        k_q     <= k_q + 6'd1;
        if (col_q == 3'd6) begin
          col_q <= '0;
          row_q <= row_q + 3'd1;
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
      fstp_pkg::ST_GDIV: begin
        dneg_q <= mul_neg;
        if (!den_ok) begin
          unique case (g_q)
            2'd0:    kp_q <= base_sel;
            2'd1:    ki_q <= base_sel;
            default: kd_q <= base_sel;
          endcase
          g_q <= g_q + 2'd1;
        end
      end
      fstp_pkg::ST_GWAIT: begin
        if (div_done) begin
          unique case (g_q)
            2'd0:    kp_q <= tuned;
            2'd1:    ki_q <= tuned;
            default: kd_q <= tuned;
          endcase
          g_q <= g_q + 2'd1;
        end
      end
      fstp_pkg::ST_IMUL: term_p_q <= mul_q;
      fstp_pkg::ST_DMUL: term_i_q <= mul_q;
      fstp_pkg::ST_DLAT: term_d_q <= mul_q;
      fstp_pkg::ST_F7:   t3_q     <= mul_q;
      fstp_pkg::ST_OUT:  drive_q  <= drv_new;
      fstp_pkg::ST_DONE: begin
        if (out_free) m_data_q <= {3'd0, kd_q, ki_q, kp_q, drive_q};
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign pready     = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      fstp_pkg::REG_BASE_P:  prdata = {1'b0, base_p_q};
      fstp_pkg::REG_BASE_I:  prdata = {1'b0, base_i_q};
      fstp_pkg::REG_BASE_D:  prdata = {1'b0, base_d_q};
      fstp_pkg::REG_ESCALE:  prdata = {1'b0, escale_q};
      fstp_pkg::REG_CSCALE:  prdata = {1'b0, cscale_q};
      fstp_pkg::REG_DRV_UP:  prdata = drv_up_q;
      fstp_pkg::REG_DRV_LO:  prdata = drv_lo_q;
      default:               prdata = {1'b0, acc_lim_q};
    endcase
  end

endmodule

FILE: sv/fstp_mul.sv
// Shared signed Q16.16 multiplier: magnitude product registered, then
// shift, truncate toward zero and saturate.
module fstp_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic        [63:0] prod_o,
  output logic               neg_o,
  output logic signed [31:0] q_o
);

  logic [31:0] mag_a, mag_b;
  logic [63:0] prod_q;
  logic        neg_q;
  logic [47:0] shr;
  logic [31:0] qmag;

  assign mag_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign mag_b = b_i[31] ? (~b_i + 32'd1) : b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= mag_a * mag_b;
    neg_q  <= a_i[31] ^ b_i[31];
  end

  assign shr  = prod_q[63:fstp_pkg::FracBits];
  assign qmag = {1'b0, shr[30:0]};

  always_comb begin
    if (|shr[47:31]) begin
      q_o = neg_q ? fstp_pkg::MIN_D : fstp_pkg::MAX_D;
    end else begin
      q_o = neg_q ? $signed(~qmag + 32'd1) : $signed(qmag);
    end
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

FILE: sv/fstp_div.sv
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit 31 bits, so the top of the dividend starts as the remainder.
module fstp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [30:0] quot_o
);

  logic [23:0] rem_q, div_q;
  logic [30:0] dq_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [24:0] rem2;
  logic        qbit;
  logic [24:0] rem_sub;

  assign rem2    = {rem_q, dq_q[30]};
  assign qbit    = rem2 >= {1'b0, div_q};
  assign rem_sub = rem2 - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(fstp_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[54:31];
      dq_q  <= dividend_i[30:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[23:0] : rem2[23:0];
      dq_q  <= {dq_q[29:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

FILE: verif/tb_fuzzy_self_tuning_pid.sv
`timescale 1ns / 100ps

module tb_fuzzy_self_tuning_pid;

  // tuser codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam int  RANDOM_ITEMS = 1930;
  localparam int  NUM_PHASES   = 8;
  localparam longint Q_ONE     = 65536;
  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam longint SAT_MIN   = -64'sd2147483648;

  // Expected drive plus the three tuned gains of one transaction.
  typedef struct packed {
    logic signed [31:0] drive;
    logic [30:0]        kp;
    logic [30:0]        ki;
    logic [30:0]        kd;
  } loop_result_t;

  // Mirror of the controller: registers, loop state, and the queue of
  // results still owed by the block.
  class drive_scoreboard;
    longint base_p, base_i, base_d, err_scale, chg_scale;
    longint drv_up, drv_lo, acc_lim;
    longint last_err, integ, smooth_d;
    loop_result_t pending_q[$];
    int errors;
    int samples;
    int clears;

    function new();
      base_p = 0; base_i = 0; base_d = 0;
      err_scale = Q_ONE; chg_scale = Q_ONE;
      drv_up = 65536000; drv_lo = -65536000; acc_lim = 32768000;
      last_err = 0; integ = 0; smooth_d = 0;
      errors = 0; samples = 0; clears = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      longint u;
      u = longint'(val[30:0]);
      case (idx)
        fstp_pkg::REG_BASE_P:  base_p = u;
        fstp_pkg::REG_BASE_I:  base_i = u;
        fstp_pkg::REG_BASE_D:  base_d = u;
        fstp_pkg::REG_ESCALE:  err_scale = u;
        fstp_pkg::REG_CSCALE:  chg_scale = u;
        fstp_pkg::REG_DRV_UP:  drv_up = longint'(signed'(val));
        fstp_pkg::REG_DRV_LO:  drv_lo = longint'(signed'(val));
        fstp_pkg::REG_ACC_LIM: acc_lim = u;
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    // Q16.16 product, truncated toward zero, saturated
    function longint qmul(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb) >> 16;
      if (p > SAT_MAX) return neg ? SAT_MIN : SAT_MAX;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function void fuzzify(longint v, longint scale, output longint m[7]);
      longint x, d, w;
      x = qmul(v, scale);
      if (x > 3 * Q_ONE) x = 3 * Q_ONE;
      if (x < -3 * Q_ONE) x = -3 * Q_ONE;
      for (int k = 0; k < 7; k++) begin
        d = x - longint'(k - 3) * Q_ONE;
        if (d < 0) d = -d;
        w = 0;
        if (d < 98304) w = (2 * (98304 - d)) / 3;
        m[k] = (w > Q_ONE / 100) ? w : 0;
      end
    endfunction

    function longint gain_delta(int sel, longint me[7], longint mc[7], longint base);
      longint num, den, w, r;
      num = 0;
      den = 0;
      for (int e = 0; e < 7; e++) begin
        for (int c = 0; c < 7; c++) begin
          if (me[e] != 0 && mc[c] != 0) begin
            w = (me[e] < mc[c]) ? me[e] : mc[c];
            case (sel)
              0: r = fstp_pkg::RULE_P[e*7+c];
              1: r = fstp_pkg::RULE_I[e*7+c];
              default: r = fstp_pkg::RULE_D[e*7+c];
            endcase
            num += w * r;
            den += w;
          end
        end
      end
      if (den == 0 || den < Q_ONE / 10000) return 0;
      return (num * (base >>> 1)) / (3 * den);
    endfunction

    function longint clip_gain(longint g);
      if (g < 0) return 0;
      if (g > SAT_MAX) return SAT_MAX;
      return g;
    endfunction

    function void note_item(logic kind, logic signed [31:0] sp, logic signed [31:0] ms);
      loop_result_t r;
      longint err, chg, kp, ki, kd, p, it, dt, drv;
      longint me[7], mc[7];
      if (kind == KIND_CLEAR) begin
        clears++;
        last_err = 0; integ = 0; smooth_d = 0;
        r.drive = '0; r.kp = base_p[30:0]; r.ki = base_i[30:0]; r.kd = base_d[30:0];
        pending_q.push_back(r);
        return;
      end
      samples++;
      err = sat(longint'(sp) - longint'(ms));
      chg = sat(err - last_err);
      fuzzify(err, err_scale, me);
      fuzzify(chg, chg_scale, mc);
      kp = clip_gain(base_p + gain_delta(0, me, mc, base_p));
      ki = clip_gain(base_i + gain_delta(1, me, mc, base_i));
      kd = clip_gain(base_d + gain_delta(2, me, mc, base_d));
      p = qmul(kp, err);
      integ = sat(integ + err);
      if (integ > acc_lim) integ = acc_lim;
      if (integ < -acc_lim) integ = -acc_lim;
      it = qmul(ki, integ);
      dt = qmul(kd, chg);
      smooth_d = sat(qmul(longint'(fstp_pkg::C3_Q), dt) +
                     qmul(longint'(fstp_pkg::C7_Q), smooth_d));
      last_err = err;
      drv = sat(p + it + smooth_d);
      if (drv > drv_up) drv = drv_up;
      if (drv < drv_lo) drv = drv_lo;   // wins when the clamps are crossed
      r.drive = drv[31:0]; r.kp = kp[30:0]; r.ki = ki[30:0]; r.kd = kd[30:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [127:0] data);
      loop_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (data[31:0] !== exp_r.drive) begin
        $display("%0t: drive expected %h actual %h", $time, exp_r.drive, data[31:0]);
        errors++;
      end
      if (data[62:32] !== exp_r.kp) begin
        $display("%0t: tuned_prop expected %h actual %h", $time, exp_r.kp, data[62:32]);
        errors++;
      end
      if (data[93:63] !== exp_r.ki) begin
        $display("%0t: tuned_integ expected %h actual %h", $time, exp_r.ki, data[93:63]);
        errors++;
      end
      if (data[124:94] !== exp_r.kd) begin
        $display("%0t: tuned_deriv expected %h actual %h", $time, exp_r.kd, data[124:94]);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [63:0]  s_tdata_i;
  logic         s_tuser_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [127:0] m_tdata_o;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  drive_scoreboard sb;
  bit              steady_flow;   // both sides skip idle cycles when set

  fuzzy_self_tuning_pid dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side checks every accepted transaction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
  end

  // Receiver: random backpressure between transactions.
  initial begin
    int gap;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
    end
  end

  // APB write: setup then access, always at falling edges.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // One sample or clear transaction; valid stays high across back-to-back items.
  task automatic send_item(logic kind, logic signed [31:0] sp, logic signed [31:0] ms);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tuser_i  = kind;
    s_tdata_i  = {ms, sp};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_item(kind, sp, ms);
    @(negedge clk_i);
  endtask

  // Hold the sender until the block has handed back everything.
  task automatic drain();
    s_tvalid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom();                      // top bit exercises masking
      default: return $urandom_range(0, 8 * 65536);
    endcase
  endfunction

  // Register set for one phase: two extreme phases, one crossed-clamp phase,
  // the rest random around useful operating points.
  task automatic load_phase(int ph);
    logic signed [31:0] up, lo;
    case (ph)
      1: begin
        for (int r = 0; r < 5; r++) reg_write(r[2:0], 32'hFFFF_FFFF);
        reg_write(fstp_pkg::REG_DRV_UP, 32'h7FFF_FFFF);
        reg_write(fstp_pkg::REG_DRV_LO, 32'h8000_0000);
        reg_write(fstp_pkg::REG_ACC_LIM, 32'h7FFF_FFFF);
      end
      2: begin
        for (int r = 0; r < 5; r++) reg_write(r[2:0], 32'h0);
        reg_write(fstp_pkg::REG_DRV_UP, 32'h0);
        reg_write(fstp_pkg::REG_DRV_LO, 32'h0);
        reg_write(fstp_pkg::REG_ACC_LIM, 32'h0);
      end
      default: begin
        reg_write(fstp_pkg::REG_BASE_P, pick_gain());
        reg_write(fstp_pkg::REG_BASE_I, pick_gain());
        reg_write(fstp_pkg::REG_BASE_D, pick_gain());
        reg_write(fstp_pkg::REG_ESCALE, $urandom_range(16384, 4 * 65536));
        reg_write(fstp_pkg::REG_CSCALE, $urandom_range(16384, 4 * 65536));
        up = $urandom_range(65536, 2000 * 65536);
        lo = -$urandom_range(65536, 2000 * 65536);
        if (ph == 3) begin
          // crossed clamps
          reg_write(fstp_pkg::REG_DRV_UP, lo);
          reg_write(fstp_pkg::REG_DRV_LO, up);
        end else begin
          reg_write(fstp_pkg::REG_DRV_UP, up);
          reg_write(fstp_pkg::REG_DRV_LO, lo);
        end
        reg_write(fstp_pkg::REG_ACC_LIM, $urandom_range(0, 1000 * 65536));
      end
    endcase
  endtask

  // Random item: mostly samples with errors inside the fuzzy range, some huge, and an occasional clear.
  task automatic send_random();
    logic signed [31:0] ms, diff;
    if ($urandom_range(0, 15) == 0) begin
      send_item(KIND_CLEAR, $urandom(), $urandom());
      return;
    end
    ms = $urandom();
    case ($urandom_range(0, 9))
      0, 1: diff = $urandom();
      2:    diff = $signed($urandom_range(0, 2 * 65536)) - 65536;
      default: diff = $signed($urandom_range(0, 10 * 65536)) - 5 * 65536;
    endcase
    if ($urandom_range(0, 3) == 0) ms = $signed($urandom_range(0, 200 * 65536)) - 100 * 65536;
    send_item(KIND_SAMPLE, ms + diff, ms);
  endtask

  initial begin
    int per_phase;
    int waited;
    sb = new();
    steady_flow = 1'b0;
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0; s_tuser_i = KIND_SAMPLE; s_tdata_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items under the reset register values first.
    send_item(KIND_SAMPLE, 32'sd131072, 32'sd0);
    drain();
    reg_write(fstp_pkg::REG_BASE_P, 2 * 65536);
    reg_write(fstp_pkg::REG_BASE_I, 6554);
    reg_write(fstp_pkg::REG_BASE_D, 32768);
    send_item(KIND_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000);   // error saturates high
    send_item(KIND_SAMPLE, 32'sh8000_0000, 32'sh7FFF_FFFF);   // and low, change too
    send_item(KIND_CLEAR, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(KIND_SAMPLE, 32'sd0, 32'sd0);
    for (int k = -3; k <= 3; k++) send_item(KIND_SAMPLE, k * 65536, 32'sd0);   // set centers
    send_item(KIND_SAMPLE, 32'sd98304, 32'sd0);    // half-width edge
    send_item(KIND_SAMPLE, -32'sd98304, 32'sd0);
    send_item(KIND_SAMPLE, 32'sd97322, 32'sd0);    // membership just at threshold
    send_item(KIND_SAMPLE, 32'sd97320, 32'sd0);
    send_item(KIND_SAMPLE, 32'sd4 * 65536, 32'sd0);  // beyond the clamp
    send_item(KIND_SAMPLE, 32'sd7, 32'sd0);
    send_item(KIND_CLEAR, 32'sd0, 32'sd0);
    drain();

    // Random phases, each starting from an idle block with fresh registers.
    per_phase = RANDOM_ITEMS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      load_phase(ph);
      steady_flow = (ph == 4);
      for (int n = 0; n < per_phase; n++) send_random();
    end
    s_tvalid_i = 1'b0;

    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (200) @(negedge clk_i);

    $display("Run covered %0d control samples and %0d clears over %0d register phases.",
             sb.samples, sb.clears, NUM_PHASES);
    $display("Phases included all-max, all-zero and crossed-clamp settings.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (sb.pending_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
